// ----- hw/rtl/iecm_pkg.sv -----
// ----------------------------------------------------------------------------
// iecm_pkg: shared types and constants for the IEC meter scale block
// Segment tables of the piecewise-linear dB scale, fixed-point widths,
// divide-by-25 reciprocal and the item structs passed between stages.
// ----------------------------------------------------------------------------
package iecm_pkg;

  localparam int CH_W   = 3;   // channel index width
  localparam int DB_W   = 16;  // dB level, Q8 signed
  localparam int LVL_W  = 18;  // meter level, units of 1/65536
  localparam int AGE_W  = 8;   // peak age and hold limit
  localparam int NSEG   = 6;   // scale segments
  localparam int SEG_W  = 3;   // segment index width
  localparam int DIFF_W = 14;  // level minus segment base, clamped top fits
  localparam int NUM_W  = 22;  // slope * diff + offset, before divide by 25
  localparam int RCP_W  = 23;  // reciprocal width
  localparam int PROD_W = NUM_W + RCP_W;
  localparam int RCP_SHIFT = 27;

  typedef logic signed [DB_W-1:0] db_t;
  typedef logic [LVL_W-1:0]       lvl_t;
  typedef logic [SEG_W-1:0]       seg_t;

  // Segment starts in Q8 dB: -70, -60, -50, -40, -30, -20
  localparam db_t SEG_BASE [NSEG] = '{
    -16'sd17920, -16'sd15360, -16'sd12800, -16'sd10240, -16'sd7680, -16'sd5120
  };
  localparam logic [7:0]  SEG_SLOPE [NSEG] = '{8'd16, 8'd32, 8'd48, 8'd96, 8'd128, 8'd160};
  localparam logic [19:0] SEG_OFFS  [NSEG] = '{
    20'd0, 20'd40960, 20'd122880, 20'd245760, 20'd491520, 20'd819200
  };

  // +40 dB maps exactly onto 2.0; anything above saturates there
  localparam db_t  DB_SAT    = 16'sd10240;
  localparam lvl_t METER_MAX = 18'd131072;

  // round(x / 25) = floor((x + 12) * ceil(2^27 / 25) / 2^27), exact for x < 2^22
  localparam logic [NUM_W-1:0] ROUND_BIAS = 22'd12;
  localparam logic [RCP_W-1:0] RCP_25     = 23'd5368710;

  localparam logic [AGE_W-1:0] HOLD_RESET = 8'd50;

  // Scaled numerator on its way to the divider
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [NUM_W-1:0] num;
  } iecm_num_t;

  // Scaled level on its way to the peak hold
  typedef struct packed {
    logic [CH_W-1:0] ch;
    lvl_t            level;
  } iecm_level_t;

endpackage

// ----- hw/rtl/iecm_scale.sv -----
// ----------------------------------------------------------------------------
// iecm_scale: dB to meter fraction, two pipeline stages
// Stage 1 picks the segment and forms slope*(d-base)+offset; stage 2 divides
// by 25 with rounding through a reciprocal multiply.
// ----------------------------------------------------------------------------
module iecm_scale (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [iecm_pkg::CH_W-1:0] ch,
  input  iecm_pkg::db_t            db,
  output logic                     lvl_valid,
  input  logic                     lvl_ready,
  output iecm_pkg::iecm_level_t    lvl
);

  logic                s1_valid;
  iecm_pkg::iecm_num_t s1;
  iecm_pkg::iecm_num_t s1_next;
  logic                s1_en;
  logic                s2_en;

  iecm_pkg::seg_t                  seg;
  logic                            below;
  iecm_pkg::db_t                   d_clamp;
  logic signed [iecm_pkg::DB_W:0]  diff_full;
  logic [iecm_pkg::DIFF_W-1:0]     diff;

  logic [iecm_pkg::NUM_W-1:0]  x;
  logic [iecm_pkg::PROD_W-1:0] prod;

  // Stage 1: segment select and linear term
  always_comb begin
    below = (db < iecm_pkg::SEG_BASE[0]);
    seg   = '0;
    for (int i = 1; i < iecm_pkg::NSEG; i++) begin
      if (db >= iecm_pkg::SEG_BASE[i]) begin
        seg = iecm_pkg::seg_t'(i);
      end
    end
    d_clamp   = (db > iecm_pkg::DB_SAT) ? iecm_pkg::DB_SAT : db;
    diff_full = {d_clamp[iecm_pkg::DB_W-1], d_clamp}
              - {iecm_pkg::SEG_BASE[seg][iecm_pkg::DB_W-1], iecm_pkg::SEG_BASE[seg]};
    diff      = diff_full[iecm_pkg::DIFF_W-1:0];
    s1_next.ch  = ch;
    s1_next.num = below ? '0
                : iecm_pkg::NUM_W'(iecm_pkg::SEG_SLOPE[seg]) * iecm_pkg::NUM_W'(diff)
                  + iecm_pkg::NUM_W'(iecm_pkg::SEG_OFFS[seg]);
  end

  // Stage 2: divide by 25, round to nearest
  assign x    = s1.num + iecm_pkg::ROUND_BIAS;
  assign prod = iecm_pkg::PROD_W'(x) * iecm_pkg::PROD_W'(iecm_pkg::RCP_25);

  assign s2_en    = !lvl_valid || lvl_ready;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      lvl_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= in_valid;
      end
      if (s2_en) begin
        lvl_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1 <= s1_next;
    end
    if (s2_en && s1_valid) begin
      lvl.ch    <= s1.ch;
      lvl.level <= prod[iecm_pkg::RCP_SHIFT +: iecm_pkg::LVL_W];
    end
  end

endmodule

// ----- hw/rtl/iecm_peak.sv -----
// ----------------------------------------------------------------------------
// iecm_peak: per-channel peak hold and result register
// Read-modify-write of peak and age is combinational ahead of the stores, so
// the same channel may follow itself without a gap. Holds the hold-limit register.
// ----------------------------------------------------------------------------
module iecm_peak #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [iecm_pkg::AGE_W-1:0] cfg_wr_data,
  input  logic                       lvl_valid,
  output logic                       lvl_ready,
  input  iecm_pkg::iecm_level_t      lvl,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [iecm_pkg::CH_W-1:0]  out_channel,
  output iecm_pkg::lvl_t             meter_level,
  output iecm_pkg::lvl_t             held_peak
);

  // Only channels the index can reach get storage
  localparam int CH_SPAN = 2 ** iecm_pkg::CH_W;
  localparam int DEPTH   = (NUM_CHANNELS < CH_SPAN) ? NUM_CHANNELS : CH_SPAN;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  iecm_pkg::lvl_t             peak_store [DEPTH];
  logic [iecm_pkg::AGE_W-1:0] age_store  [DEPTH];
  logic [iecm_pkg::AGE_W-1:0] hold_limit;

  logic                          accept;
  logic                          in_range;
  logic [IDX_W+iecm_pkg::CH_W-1:0] ch_ext;
  logic [IDX_W-1:0]              idx;
  iecm_pkg::lvl_t                peak_rd;
  logic [iecm_pkg::AGE_W:0]      age_inc;
  logic                          replace;
  iecm_pkg::lvl_t                peak_next;
  logic [iecm_pkg::AGE_W-1:0]    age_next;

  assign lvl_ready = !out_valid || out_ready;
  assign accept    = lvl_valid && lvl_ready;

  assign in_range = ({{(32 - iecm_pkg::CH_W){1'b0}}, lvl.ch} < 32'(NUM_CHANNELS));
  assign ch_ext   = {{IDX_W{1'b0}}, lvl.ch};
  assign idx      = ch_ext[IDX_W-1:0];

  // age is one bit wider so it never wraps before exceeding the limit
  always_comb begin
    peak_rd   = in_range ? peak_store[idx] : '0;
    age_inc   = {1'b0, (in_range ? age_store[idx] : '0)} + 1'b1;
    replace   = (peak_rd < lvl.level) || (age_inc > {1'b0, hold_limit});
    peak_next = replace ? lvl.level : peak_rd;
    age_next  = replace ? '0 : age_inc[iecm_pkg::AGE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        peak_store[i] <= '0;
        age_store[i]  <= '0;
      end
      hold_limit <= iecm_pkg::HOLD_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hold_limit <= cfg_wr_data;
      end
      if (accept && in_range) begin
        peak_store[idx] <= peak_next;
        age_store[idx]  <= age_next;
      end
      if (lvl_ready) begin
        out_valid <= lvl_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_channel <= lvl.ch;
      meter_level <= lvl.level;
      held_peak   <= in_range ? peak_next : '0;
    end
  end

endmodule

// ----- hw/rtl/iec_meter_scale_peak_hold.sv -----
// ----------------------------------------------------------------------------
// iec_meter_scale_peak_hold: IEC dB meter scale with per-channel peak hold
// Path from input transfer to result valid: three register stages (scale,
// divide, hold).
// Throughput: one item per cycle while the output is not stalled; the peak read-modify-write lets a channel repeat.
// Reset (rst, synchronous): clears all peaks and ages, empties the pipeline and
// loads the hold limit with 50.
// ----------------------------------------------------------------------------
module iec_meter_scale_peak_hold #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // hold-limit register write
  input  logic                       cfg_wr_en,
  input  logic [iecm_pkg::AGE_W-1:0] cfg_wr_data,
  // input items
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [iecm_pkg::CH_W-1:0]  channel_index,
  input  logic signed [15:0]         db_level,
  // results
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [iecm_pkg::CH_W-1:0]  out_channel,
  output logic [17:0]                meter_level,
  output logic [17:0]                held_peak
);

  // Scaled level between the scale pipe and the peak hold stage.
  // Each stage moves when its output is empty or being taken, so a
  // result waiting at the output only stalls once every stage is full.
  logic                  lvl_valid;
  logic                  lvl_ready;
  iecm_pkg::iecm_level_t lvl;

  // Piecewise-linear scale: segment select and linear term, then the
  // rounded divide by 25 as a reciprocal multiply.
  iecm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (channel_index),
    .db        (db_level),
    .lvl_valid (lvl_valid),
    .lvl_ready (lvl_ready),
    .lvl       (lvl)
  );

  // Peak hold: peak and age per channel, updated on each transfer.
  // A channel beyond NUM_CHANNELS leaves state alone and reports peak 0.
  iecm_peak #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_peak (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .lvl_valid   (lvl_valid),
    .lvl_ready   (lvl_ready),
    .lvl         (lvl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .meter_level (meter_level),
    .held_peak   (held_peak)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Scale saturates at 2.0
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> meter_level <= iecm_pkg::METER_MAX)
    else $error("meter level above 2.0");

  // A held peak never sits below the level that just passed through it
  a_peak_ge_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ({29'b0, out_channel} < 32'(NUM_CHANNELS)))
      |-> held_peak >= meter_level)
    else $error("held peak below current level");

  // Unbacked channels report no peak
  a_unbacked_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ({29'b0, out_channel} >= 32'(NUM_CHANNELS)))
      |-> held_peak == '0)
    else $error("peak reported for a channel without storage");

endmodule

// ----- sim/tb_iec_meter_scale_peak_hold.sv -----
// ----------------------------------------------------------------------------
// tb_iec_meter_scale_peak_hold: testbench for the IEC meter scale / peak hold
// Streams dB levels through the block under random stalls on both sides. It
// predicts each meter level and held peak with its own scale and per-channel
// hold state, and compares every result field in order. The hold limit is
// swept across several values, the extremes among them.
// ----------------------------------------------------------------------------
module tb_iec_meter_scale_peak_hold;

  localparam int NCH        = 8;
  localparam int IDLE_PCT   = 22;       // chance per cycle that a side idles
  localparam int DRAIN_WAIT = 8;        // settle margin after the last result
  localparam longint METER_FULL = 131072; // 2.0 in 1/65536 units

  // one input transfer waiting to be driven
  typedef struct {
    logic [iecm_pkg::CH_W-1:0] ch;
    logic signed [15:0]        db;
  } level_item_t;

  // one result as it should come out
  typedef struct {
    logic [iecm_pkg::CH_W-1:0] ch;
    logic [17:0]               level;
    logic [17:0]               peak;
  } meter_result_t;

  logic                         clk;
  logic                         rst         = 1'b1;
  logic                         cfg_wr_en   = 1'b0;
  logic [iecm_pkg::AGE_W-1:0]   cfg_wr_data = '0;
  logic                         in_valid    = 1'b0;
  logic                         in_ready;
  logic [iecm_pkg::CH_W-1:0]    channel_index = '0;
  logic signed [15:0]           db_level    = '0;
  logic                         out_valid;
  logic                         out_ready   = 1'b0;
  logic [iecm_pkg::CH_W-1:0]    out_channel;
  logic [17:0]                  meter_level;
  logic [17:0]                  held_peak;

  // stimulus and expectation stores
  level_item_t   level_queue[$];
  meter_result_t meter_expect[$];
  level_item_t   next_level;
  meter_result_t got_result;
  meter_result_t want_result;

  // mirror of the block's hold state
  logic [17:0]                peak_mem [NCH];
  logic [iecm_pkg::AGE_W-1:0] age_mem  [NCH];
  logic [iecm_pkg::AGE_W-1:0] hold_limit = iecm_pkg::HOLD_RESET;

  bit no_idle = 1'b0;   // set during the stall-free stretch
  int mismatch_count = 0;

  iec_meter_scale_peak_hold #(.NUM_CHANNELS(NCH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .channel_index(channel_index),
    .db_level     (db_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .meter_level  (meter_level),
    .held_peak    (held_peak)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(12 * 400000);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Piecewise-linear IEC scale in fixed point. Levels are Q8 dB. Each segment
  // is round((slope * (d - start) + offset) / 25); a level on a boundary
  // goes to the upper segment. Top segment runs on and clips at 2.0.
  function automatic logic [17:0] scale_db_to_meter(input logic signed [15:0] d);
    longint start, slope, offs, q;
    if (d < -17920) begin
      return '0;                       // below -70 dB: meter reads zero
    end else if (d < -15360) begin
      start = -17920; slope = 16;  offs = 0;
    end else if (d < -12800) begin
      start = -15360; slope = 32;  offs = 40960;
    end else if (d < -10240) begin
      start = -12800; slope = 48;  offs = 122880;
    end else if (d < -7680) begin
      start = -10240; slope = 96;  offs = 245760;
    end else if (d < -5120) begin
      start = -7680;  slope = 128; offs = 491520;
    end else begin
      start = -5120;  slope = 160; offs = 819200;
    end
    q = (slope * (longint'(d) - start) + offs + 12) / 25;
    if (q > METER_FULL) q = METER_FULL;
    return q[17:0];
  endfunction

  // Update one channel's hold state for an accepted level and queue the
  // result it should produce.
  task automatic predict_meter(input logic [iecm_pkg::CH_W-1:0] ch,
                               input logic signed [15:0] d);
    meter_result_t r;
    logic [iecm_pkg::AGE_W:0] age;   // one bit wider so an age of 256 never wraps
    r.ch    = ch;
    r.level = scale_db_to_meter(d);
    r.peak  = '0;
    if (ch < NCH) begin
      age = {1'b0, age_mem[ch]} + 1'b1;
      if (peak_mem[ch] < r.level || age > {1'b0, hold_limit}) begin
        age_mem[ch]  = '0;
        peak_mem[ch] = r.level;
      end else begin
        age_mem[ch] = age[iecm_pkg::AGE_W-1:0];
      end
      r.peak = peak_mem[ch];
    end
    meter_expect.push_back(r);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued levels, holding each until its transfer. The
  // accepted item is predicted at the same edge it transfers.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_meter(channel_index, db_level);
      if (!in_valid || in_ready) begin
        if (level_queue.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          next_level = level_queue.pop_front();
          in_valid      <= 1'b1;
          channel_index <= next_level.ch;
          db_level      <= next_level.db;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random backpressure; every result transfer is checked against
  // the oldest prediction, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_result.ch    = out_channel;
        got_result.level = meter_level;
        got_result.peak  = held_peak;
        if (meter_expect.size() == 0) begin
          flag_mismatch($sformatf("result with none pending: ch %0d level %0d peak %0d",
                                  got_result.ch, got_result.level, got_result.peak));
        end else begin
          want_result = meter_expect.pop_front();
          if (got_result.ch !== want_result.ch)
            flag_mismatch($sformatf("out_channel %0d, want %0d",
                                    got_result.ch, want_result.ch));
          if (got_result.level !== want_result.level)
            flag_mismatch($sformatf("ch %0d meter_level %0d, want %0d",
                                    want_result.ch, got_result.level, want_result.level));
          if (got_result.peak !== want_result.peak)
            flag_mismatch($sformatf("ch %0d held_peak %0d, want %0d",
                                    want_result.ch, got_result.peak, want_result.peak));
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_level(input int ch, input int d);
    level_item_t it;
    it.ch = ch[iecm_pkg::CH_W-1:0];
    it.db = d[15:0];
    level_queue.push_back(it);
  endtask

  // Mostly levels in and around the meter's range (-80..+45 dB), the rest
  // anywhere in the 16-bit field.
  function automatic int pick_db();
    if ($urandom_range(99) < 65) return $urandom_range(11520 + 20480) - 20480;
    return $urandom_range(65535) - 32768;
  endfunction

  // n random levels; focus_pct of them land on focus_ch when it is >= 0.
  task automatic queue_random_levels(input int n, input int focus_ch, input int focus_pct);
    int ch;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(NCH - 1);
      if (focus_ch >= 0 && $urandom_range(99) < focus_pct) ch = focus_ch;
      queue_level(ch, pick_db());
    end
  endtask

  // Wait until every queued level has transferred and every result is in,
  // then let the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (level_queue.size() != 0 || in_valid || meter_expect.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Limit writes only ever happen with the block idle.
  task automatic write_hold_limit(input int v);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[iecm_pkg::AGE_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    hold_limit = v[iecm_pkg::AGE_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NCH; i++) begin
      peak_mem[i] = '0;
      age_mem[i]  = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and both sides of every segment boundary,
    // including the floor below -70 dB and clipping at +40 dB.
    queue_level(0, -32768);
    queue_level(7, 32767);
    queue_level(1, -17921);
    queue_level(1, -17920);
    queue_level(2, -15361);
    queue_level(2, -15360);
    queue_level(3, -12801);
    queue_level(3, -12800);
    queue_level(4, -10241);
    queue_level(4, -10240);
    queue_level(5, -7681);
    queue_level(5, -7680);
    queue_level(6, -5121);
    queue_level(6, -5120);
    queue_level(7, 0);
    queue_level(0, -1);
    queue_level(0, 10239);
    queue_level(0, 10240);
    queue_level(0, 10241);
    queue_level(7, -256);   // lower than held clip: peak holds
    queue_level(7, -25600);

    // Limit 0: any repeat on a channel replaces the peak.
    write_hold_limit(0);
    queue_random_levels(200, -1, 0);

    // Limit 255: pin channel 5 at full scale, then keep it busy with lower
    // or equal levels long enough that the age runs past 255.
    write_hold_limit(255);
    queue_level(5, 10240);
    queue_random_levels(380, 5, 75);

    // Mid-range limit with no stalls on either side.
    write_hold_limit($urandom_range(254, 1));
    wait_drained();
    no_idle = 1'b1;
    queue_random_levels(250, -1, 0);
    wait_drained();
    no_idle = 1'b0;

    // Short hold: peaks time out often.
    write_hold_limit(4);
    queue_random_levels(200, 2, 40);

    // Back to the reset value.
    write_hold_limit(iecm_pkg::HOLD_RESET);
    queue_random_levels(100, -1, 0);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
